[hdl/lbfm_pkg.sv]
// Shared types and constants for the four-momentum Lorentz boost pipeline.
`timescale 1ns / 1ps

package lbfm_pkg;

   // Fraction bits of the momentum format (Q16.16).
   localparam int MOM_FRAC = 16;

   // Pipeline control handed to the iterative arithmetic units.
   typedef struct packed {
      logic adv;   // all pipeline registers advance this cycle
      logic vld;   // the item entering the unit is valid
   } lbfm_ctl_type;

endpackage

[hdl/lorentz_boost_four_momentum_top.sv]
// Top level of the fixed-point Lorentz boost of a four-momentum.
// The pipeline depth is set by the gamma divider (2*VEL_WIDTH+31 stages), square root
// (VEL_WIDTH+16) and correction divider.
// Throughput: one transaction per cycle; the whole pipeline stalls only while a
// result waits at the output and rsp_tready is low.
// Reset clears every valid bit at once; data registers are not reset.
`timescale 1ns / 1ps

module lorentz_boost_four_momentum_top #(
   parameter int MOM_WIDTH = 32,
   parameter int VEL_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: vel_x, vel_y, vel_z, energy_in, mom_x_in, mom_y_in, mom_z_in, zero fill
   input  logic [((3*VEL_WIDTH+4*MOM_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_tuser: opcode
   input  logic                                    req_tuser,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // rsp_tdata: energy_out, mom_x_out, mom_y_out, mom_z_out, zero fill
   output logic [((4*MOM_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // rsp_tuser: error_flag
   output logic                                    rsp_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready
);

   localparam int MF      = lbfm_pkg::MOM_FRAC;
   localparam int MW      = MOM_WIDTH;
   localparam int VW      = VEL_WIDTH;
   localparam int VF      = VW - 1;
   localparam int RSP_W   = ((4*MW+7)/8)*8;
   localparam int VN_W    = VW + 1;
   localparam int SQ_W    = 2*VW;
   localparam int D_W     = 2*VF + 1;
   localparam int N1_W    = 2*MF + 2*VF + 1;
   localparam int RAD_W   = N1_W + (N1_W % 2);
   localparam int G_W     = RAD_W / 2;
   localparam int PROD_W  = MW + VN_W;
   localparam int PS_W    = PROD_W + 2;
   localparam int PP_W    = PS_W - VF;
   localparam int N2_W    = PP_W + MF;
   localparam int DEN2_W  = G_W + 1;
   localparam int X_W     = PP_W + 2;
   localparam int XL_W    = X_W / 2;
   localparam int XH_W    = X_W - XL_W;
   localparam int PL_W    = XL_W + G_W + 2;
   localparam int PH_W    = XH_W + G_W + 1;
   localparam int XG_W    = X_W + G_W + 1;
   localparam int GV_W    = XG_W - MF;
   localparam int GL_W    = GV_W / 2;
   localparam int GH_W    = GV_W - GL_W;
   localparam int QL_W    = GL_W + 1 + VN_W;
   localparam int QH_W    = GH_W + VN_W;
   localparam int GVV_W   = GV_W + VN_W;
   localparam int SH_W    = GVV_W - VF;
   localparam int Y_W     = SH_W + 1;
   // First side band: velocities, momenta, energy, p.v, speed error.
   localparam int S1_P    = 3*VN_W;
   localparam int S1_E    = S1_P + 3*MW;
   localparam int S1_PP   = S1_E + MW;
   localparam int S1_ERR  = S1_PP + PP_W;
   localparam int SIDE1_W = S1_ERR + 1;
   // Second side band: velocities, momenta, p.v - E, E - p.v, sign, error, gamma.
   localparam int S2_PME  = S1_P + 3*MW;
   localparam int S2_X2   = S2_PME + X_W;
   localparam int S2_NEG  = S2_X2 + X_W;
   localparam int S2_ERR  = S2_NEG + 1;
   localparam int S2_G    = S2_ERR + 1;
   localparam int SIDE2_W = S2_G + G_W;

   localparam logic [SQ_W-1:0] VSQ_ONE = SQ_W'(1) << (2*VF);
   localparam logic [N1_W-1:0] NUM1    = N1_W'(1) << (N1_W-1);
   localparam logic [MW-1:0]   SAT_MAX = {1'b0, {(MW-1){1'b1}}};
   localparam logic [MW-1:0]   SAT_MIN = {1'b1, {(MW-1){1'b0}}};

   logic adv;

   // ---------------- Front end: products and p.v ----------------
   logic                     f1_vld_ff;
   logic signed [VN_W-1:0]   f1_vn_ff   [3];
   logic signed [SQ_W-1:0]   f1_sq_ff   [3];
   logic signed [PROD_W-1:0] f1_prod_ff [3];
   logic signed [MW-1:0]     f1_p_ff    [3];
   logic signed [MW-1:0]     f1_e_ff;
   logic signed [VW-1:0]     vel_s      [3];
   logic signed [MW-1:0]     mom_s      [3];
   logic signed [VN_W-1:0]   f1_vn_in   [3];

   logic                     f2_vld_ff;
   logic [D_W-1:0]           f2_d_ff;
   logic signed [PP_W-1:0]   f2_pp_ff;
   logic                     f2_err_ff;
   logic signed [VN_W-1:0]   f2_vn_ff   [3];
   logic signed [MW-1:0]     f2_p_ff    [3];
   logic signed [MW-1:0]     f2_e_ff;
   logic [SQ_W-1:0]          f2_vsq_in;
   logic signed [PS_W-1:0]   f2_psum_in;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Unpack the request and, when req_tuser is set, negate the velocity for the return boost.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel_s[i]    = $signed(req_tdata[i*VW +: VW]);
         mom_s[i]    = $signed(req_tdata[3*VW + (i+1)*MW +: MW]);
         f1_vn_in[i] = req_tuser ? -VN_W'(vel_s[i]) : VN_W'(vel_s[i]);
      end
   end

   // Stage one: squares of the velocity and momentum-velocity products.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= req_tvalid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            f1_vn_ff[i]   <= f1_vn_in[i];
            f1_sq_ff[i]   <= vel_s[i] * vel_s[i];
            f1_prod_ff[i] <= mom_s[i] * f1_vn_in[i];
            f1_p_ff[i]    <= mom_s[i];
         end
         f1_e_ff <= $signed(req_tdata[3*VW +: MW]);
      end
   end

   // Stage two: |v|^2 against one, 1 - |v|^2 and p.v in momentum format.
   always_comb begin
      f2_vsq_in  = $unsigned(f1_sq_ff[0]) + $unsigned(f1_sq_ff[1]) + $unsigned(f1_sq_ff[2]);
      f2_psum_in = PS_W'(f1_prod_ff[0]) + PS_W'(f1_prod_ff[1]) + PS_W'(f1_prod_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f2_vld_ff <= f1_vld_ff;
      end
      if (adv) begin
         f2_err_ff <= (f2_vsq_in >= VSQ_ONE);
         f2_d_ff   <= D_W'(VSQ_ONE - f2_vsq_in);
         f2_pp_ff  <= f2_psum_in[PS_W-1:VF];
         f2_vn_ff  <= f1_vn_ff;
         f2_p_ff   <= f1_p_ff;
         f2_e_ff   <= f1_e_ff;
      end
   end

   // ---------------- Gamma: 2^62 / d, then square root ----------------
   logic [SIDE1_W-1:0]    side1_in;
   logic                  d1_vld;
   logic [N1_W-1:0]       d1_quo;
   logic [SIDE1_W-1:0]    d1_side;
   logic                  sq_vld;
   logic [G_W-1:0]        sq_root;
   logic [SIDE1_W-1:0]    sq_side;
   lbfm_pkg::lbfm_ctl_type d1_ctl;
   lbfm_pkg::lbfm_ctl_type sq_ctl;

   assign side1_in = {f2_err_ff, f2_pp_ff, f2_e_ff, f2_p_ff[2], f2_p_ff[1], f2_p_ff[0],
                      f2_vn_ff[2], f2_vn_ff[1], f2_vn_ff[0]};
   assign d1_ctl   = '{adv: adv, vld: f2_vld_ff};
   assign sq_ctl   = '{adv: adv, vld: d1_vld};

   lbfm_div #(
      .NUM_W  (N1_W),
      .DEN_W  (D_W),
      .SIDE_W (SIDE1_W)
   ) u_gamma_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (d1_ctl),
      .in_num   (NUM1),
      .in_den   (f2_d_ff),
      .in_side  (side1_in),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   lbfm_sqrt #(
      .RAD_W  (RAD_W),
      .SIDE_W (SIDE1_W)
   ) u_gamma_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sq_ctl),
      .in_rad   (RAD_W'(d1_quo)),
      .in_side  (d1_side),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // ---------------- Operands of the correction divide ----------------
   logic signed [PP_W-1:0] sq_pp;
   logic signed [MW-1:0]   sq_e;
   logic                   sq_err;

   logic                   g_vld_ff;
   logic [PP_W-1:0]        g_mag_ff;
   logic [DEN2_W-1:0]      g_den_ff;
   logic [SIDE2_W-1:0]     g_side_ff;
   logic signed [X_W-1:0]  g_pme_in;
   logic signed [X_W-1:0]  g_x2_in;

   always_comb begin
      sq_pp    = $signed(sq_side[S1_PP +: PP_W]);
      sq_e     = $signed(sq_side[S1_E +: MW]);
      sq_err   = sq_side[S1_ERR];
      g_pme_in = X_W'(sq_pp) - X_W'(sq_e);
      g_x2_in  = X_W'(sq_e) - X_W'(sq_pp);
   end

   // |p.v| shifted into the numerator, gamma + 1 as divisor.
   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= sq_vld;
      end
      if (adv) begin
         g_mag_ff  <= sq_pp[PP_W-1] ? PP_W'(-sq_pp) : PP_W'(sq_pp);
         g_den_ff  <= DEN2_W'(sq_root) + (DEN2_W'(1) << MF);
         g_side_ff <= {sq_root, sq_err, sq_pp[PP_W-1], g_x2_in, g_pme_in,
                       sq_side[S1_P +: 3*MW], sq_side[0 +: 3*VN_W]};
      end
   end

   logic                   d2_vld;
   logic [N2_W-1:0]        d2_quo;
   logic [SIDE2_W-1:0]     d2_side;
   lbfm_pkg::lbfm_ctl_type d2_ctl;

   assign d2_ctl = '{adv: adv, vld: g_vld_ff};

   lbfm_div #(
      .NUM_W  (N2_W),
      .DEN_W  (DEN2_W),
      .SIDE_W (SIDE2_W)
   ) u_corr_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (d2_ctl),
      .in_num   ({g_mag_ff, {MF{1'b0}}}),
      .in_den   (g_den_ff),
      .in_side  (g_side_ff),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // ---------------- Back end: products with gamma and velocity ----------------
   logic signed [X_W-1:0]   d2_pme;
   logic signed [X_W-1:0]   d2_q;
   logic signed [VN_W-1:0]  d2_vn [3];
   logic signed [MW-1:0]    d2_p  [3];

   logic                    e1_vld_ff;
   logic signed [X_W-1:0]   e1_x1_ff;
   logic signed [X_W-1:0]   e1_x2_ff;
   logic [G_W-1:0]          e1_g_ff;
   logic signed [VN_W-1:0]  e1_vn_ff [3];
   logic signed [MW-1:0]    e1_p_ff  [3];
   logic                    e1_err_ff;

   always_comb begin
      d2_pme = $signed(d2_side[S2_PME +: X_W]);
      d2_q   = $signed(X_W'(d2_quo[PP_W-1:0]));
      for (int i = 0; i < 3; i++) begin
         d2_vn[i] = $signed(d2_side[i*VN_W +: VN_W]);
         d2_p[i]  = $signed(d2_side[S1_P + i*MW +: MW]);
      end
   end

   // E1: (p.v - corr) - E, with corr carrying the sign of p.v.
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_vld_ff <= 1'b0;
      end else if (adv) begin
         e1_vld_ff <= d2_vld;
      end
      if (adv) begin
         e1_x1_ff  <= d2_side[S2_NEG] ? d2_pme + d2_q : d2_pme - d2_q;
         e1_x2_ff  <= $signed(d2_side[S2_X2 +: X_W]);
         e1_g_ff   <= d2_side[S2_G +: G_W];
         e1_err_ff <= d2_side[S2_ERR];
         e1_vn_ff  <= d2_vn;
         e1_p_ff   <= d2_p;
      end
   end

   // E2: both gamma products split into two partial products each.
   logic                    e2_vld_ff;
   logic signed [PL_W-1:0]  e2_x1lo_ff;
   logic signed [PH_W-1:0]  e2_x1hi_ff;
   logic signed [PL_W-1:0]  e2_x2lo_ff;
   logic signed [PH_W-1:0]  e2_x2hi_ff;
   logic signed [VN_W-1:0]  e2_vn_ff [3];
   logic signed [MW-1:0]    e2_p_ff  [3];
   logic                    e2_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_vld_ff <= 1'b0;
      end else if (adv) begin
         e2_vld_ff <= e1_vld_ff;
      end
      if (adv) begin
         e2_x1lo_ff <= $signed({1'b0, e1_x1_ff[XL_W-1:0]}) * $signed({1'b0, e1_g_ff});
         e2_x1hi_ff <= $signed(e1_x1_ff[X_W-1:XL_W]) * $signed({1'b0, e1_g_ff});
         e2_x2lo_ff <= $signed({1'b0, e1_x2_ff[XL_W-1:0]}) * $signed({1'b0, e1_g_ff});
         e2_x2hi_ff <= $signed(e1_x2_ff[X_W-1:XL_W]) * $signed({1'b0, e1_g_ff});
         e2_vn_ff   <= e1_vn_ff;
         e2_p_ff    <= e1_p_ff;
         e2_err_ff  <= e1_err_ff;
      end
   end

   // E3: recombine and take the floor of the product over 2^16.
   logic signed [XG_W-1:0]  e3_x1g_in;
   logic signed [XG_W-1:0]  e3_x2g_in;
   logic                    e3_vld_ff;
   logic signed [GV_W-1:0]  e3_gavv_ff;
   logic signed [GV_W-1:0]  e3_eo_ff;
   logic signed [VN_W-1:0]  e3_vn_ff [3];
   logic signed [MW-1:0]    e3_p_ff  [3];
   logic                    e3_err_ff;

   always_comb begin
      e3_x1g_in = (XG_W'(e2_x1hi_ff) <<< XL_W) + XG_W'(e2_x1lo_ff);
      e3_x2g_in = (XG_W'(e2_x2hi_ff) <<< XL_W) + XG_W'(e2_x2lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e3_vld_ff <= 1'b0;
      end else if (adv) begin
         e3_vld_ff <= e2_vld_ff;
      end
      if (adv) begin
         e3_gavv_ff <= e3_x1g_in[XG_W-1:MF];
         e3_eo_ff   <= e3_x2g_in[XG_W-1:MF];
         e3_vn_ff   <= e2_vn_ff;
         e3_p_ff    <= e2_p_ff;
         e3_err_ff  <= e2_err_ff;
      end
   end

   // E4: gamma term times each velocity component, split in two halves.
   logic                    e4_vld_ff;
   logic signed [QL_W-1:0]  e4_lo_ff [3];
   logic signed [QH_W-1:0]  e4_hi_ff [3];
   logic signed [GV_W-1:0]  e4_eo_ff;
   logic signed [MW-1:0]    e4_p_ff  [3];
   logic                    e4_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e4_vld_ff <= 1'b0;
      end else if (adv) begin
         e4_vld_ff <= e3_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e4_lo_ff[i] <= $signed({1'b0, e3_gavv_ff[GL_W-1:0]}) * e3_vn_ff[i];
            e4_hi_ff[i] <= $signed(e3_gavv_ff[GV_W-1:GL_W]) * e3_vn_ff[i];
         end
         e4_eo_ff  <= e3_eo_ff;
         e4_p_ff   <= e3_p_ff;
         e4_err_ff <= e3_err_ff;
      end
   end

   // E5: recombine and floor over 2^15.
   logic signed [GVV_W-1:0] e5_full_in [3];
   logic                    e5_vld_ff;
   logic signed [SH_W-1:0]  e5_sh_ff [3];
   logic signed [GV_W-1:0]  e5_eo_ff;
   logic signed [MW-1:0]    e5_p_ff  [3];
   logic                    e5_err_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e5_full_in[i] = (GVV_W'(e4_hi_ff[i]) <<< GL_W) + GVV_W'(e4_lo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e5_vld_ff <= 1'b0;
      end else if (adv) begin
         e5_vld_ff <= e4_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e5_sh_ff[i] <= e5_full_in[i][GVV_W-1:VF];
         end
         e5_eo_ff  <= e4_eo_ff;
         e5_p_ff   <= e4_p_ff;
         e5_err_ff <= e4_err_ff;
      end
   end

   // ---------------- Output: add momentum, saturate, error ----------------
   logic signed [Y_W-1:0]   out_val [4];
   logic [MW-1:0]           out_sat [4];
   logic [3:0]              out_ovf;
   logic [Y_W-MW:0]         out_top [4];

   logic                    rsp_vld_ff;
   logic [4*MW-1:0]         rsp_data_ff;
   logic                    rsp_err_ff;
   logic                    rsp_spd_ff;

   always_comb begin
      out_val[0] = Y_W'(e5_eo_ff);
      for (int i = 0; i < 3; i++) begin
         out_val[i+1] = Y_W'(e5_sh_ff[i]) + Y_W'(e5_p_ff[i]);
      end
      for (int i = 0; i < 4; i++) begin
         out_top[i] = out_val[i][Y_W-1:MW-1];
         out_ovf[i] = !((&out_top[i]) || !(|out_top[i]));
         out_sat[i] = out_ovf[i] ? (out_val[i][Y_W-1] ? SAT_MIN : SAT_MAX)
                                 : out_val[i][MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= e5_vld_ff;
      end
      if (adv) begin
         rsp_spd_ff  <= e5_err_ff;
         rsp_err_ff  <= e5_err_ff || (|out_ovf);
         rsp_data_ff <= e5_err_ff ? '0 : {out_sat[3], out_sat[2], out_sat[1], out_sat[0]};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_err_ff;

   // ---------------- Assertions ----------------
   // No result appears in the cycle after reset.
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // A speed of one or more gives an all-zero result with the error flag.
   a_speed_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_spd_ff |-> rsp_tdata == '0 && rsp_tuser)
      else $error("speed error result is not zero with error flag");

   // Gamma is never below one for a speed below one.
   a_gamma_min : assert property (@(posedge clock) disable iff (reset)
      sq_vld && !sq_err |-> sq_root >= (G_W'(1) << MF))
      else $error("gamma below one");

endmodule

[hdl/lbfm_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module lbfm_div #(
   parameter int NUM_W  = 63,
   parameter int DEN_W  = 31,
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lbfm_pkg::lbfm_ctl_type    ctl,
   input  logic [NUM_W-1:0]          in_num,
   input  logic [DEN_W-1:0]          in_den,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_vld,
   output logic [NUM_W-1:0]          out_quo,
   output logic [SIDE_W-1:0]         out_side
);

   logic              vld_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [NUM_W-1:0]  quo_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              src_vld;
      logic [NUM_W-1:0]  src_num;
      logic [NUM_W-1:0]  src_quo;
      logic [DEN_W-1:0]  src_rem;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;

      // The first stage starts from the operands with an empty remainder.
      if (k == 0) begin : g_first
         assign src_vld  = ctl.vld;
         assign src_num  = in_num;
         assign src_quo  = '0;
         assign src_rem  = '0;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_num  = num_ff[k-1];
         assign src_quo  = quo_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // Bring down the next numerator bit and try to subtract the divisor.
      always_comb begin
         trial = {src_rem, src_num[NUM_W-1]};
         diff  = trial - {1'b0, src_den};
         ge    = (trial >= {1'b0, src_den});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.adv) begin
            vld_ff[k] <= src_vld;
         end
         if (ctl.adv) begin
            num_ff[k]  <= src_num << 1;
            quo_ff[k]  <= {src_quo[NUM_W-2:0], ge};
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k]  <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign out_quo  = quo_ff[NUM_W-1];
   assign out_side = side_ff[NUM_W-1];

endmodule

[hdl/lbfm_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module lbfm_sqrt #(
   parameter int RAD_W  = 64,
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lbfm_pkg::lbfm_ctl_type    ctl,
   input  logic [RAD_W-1:0]          in_rad,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_vld,
   output logic [RAD_W/2-1:0]        out_root,
   output logic [SIDE_W-1:0]         out_side
);

   localparam int RT_W  = RAD_W / 2;
   localparam int REM_W = RT_W + 2;

   logic              vld_ff  [RT_W];
   logic [RAD_W-1:0]  rad_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [REM_W-1:0]  rem_ff  [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_stage
      logic              src_vld;
      logic [RAD_W-1:0]  src_rad;
      logic [RT_W-1:0]   src_root;
      logic [REM_W-1:0]  src_rem;
      logic [SIDE_W-1:0] src_side;
      logic [REM_W+1:0]  shifted;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign src_vld  = ctl.vld;
         assign src_rad  = in_rad;
         assign src_root = '0;
         assign src_rem  = '0;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_rad  = rad_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // Bring down the next bit pair and test against four times the root plus one.
      always_comb begin
         shifted = {src_rem, src_rad[RAD_W-1:RAD_W-2]};
         trial   = (REM_W+2)'({src_root, 2'b01});
         diff    = shifted - trial;
         ge      = (shifted >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (ctl.adv) begin
            vld_ff[k] <= src_vld;
         end
         if (ctl.adv) begin
            rad_ff[k]  <= src_rad << 2;
            root_ff[k] <= {src_root[RT_W-2:0], ge};
            rem_ff[k]  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[RT_W-1];
   assign out_root = root_ff[RT_W-1];
   assign out_side = side_ff[RT_W-1];

endmodule
